[design/wpt_pkg.sv]
// Package for the Wilson primality tester: sizes, state encoding and the number type.
// Used by the interfaces, the top level and the checker. Depends on nothing.
package wpt_pkg;

  // Width of the number that is actually tested (low bits of the request field).
  localparam int NUMBER_WIDTH = 32;
  // Number of entries in the map of primes already found.
  localparam int CACHE_DEPTH  = 1024;
  localparam int CACHE_AW     = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  // Counter width for the bit steps of one division.
  localparam int CNT_W        = $clog2(NUMBER_WIDTH);
  // Fixed width of the request payload field.
  localparam int PORT_W       = 32;

  typedef logic [NUMBER_WIDTH-1:0] num_t;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_LOOKUP = 6'b000100,
    ST_DIVIDE = 6'b001000,
    ST_CHECK  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

endpackage

[design/wpt_if.sv]
// Valid/ready channel interfaces of the Wilson primality tester.
// Depends on wpt_pkg for the width of the request field.
interface wpt_in_if;
  logic                      valid;
  logic                      ready;
  logic [wpt_pkg::PORT_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface wpt_out_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

[design/wilson_primality_test.sv]
// Top level of the Wilson primality tester: sequencer, shared divider and prime map.
// Depends on wpt_pkg and on the interfaces wpt_in_if and wpt_out_if.
//
// The block answers, for each request, whether the low NUMBER_WIDTH bits of number form a
// prime. Zero and one are reported as not prime. The answer is the one Wilson's theorem
// gives ((n-1)! + 1 is 0 mod n); it is computed by the equivalent trial division with odd
// divisors d = 3, 5, 7, ... up to the square root of n, run on one shared restoring
// divider that produces one quotient bit per cycle. After reset the block first sweeps
// the map of known primes clear, one entry per cycle, and takes no request until all
// CACHE_DEPTH (1024) entries are cleared. It then works on one request at a time and holds
// request.ready low until the answer has been placed in the output register. Zero, one,
// two, three, even numbers and numbers below CACHE_DEPTH already found prime are decided
// in the lookup state without the divider. Any other odd number runs a full division for
// each trial divisor, and up to about sqrt(n)/2 divisors are tried; a composite stops at
// its smallest odd factor. A result waits in the output register until result.ready
// takes it; the next request may be accepted while it waits.
module wilson_primality_test (
  input  logic        clk,
  input  logic        rst,
  wpt_in_if.sink      request,
  wpt_out_if.source   result
);

  localparam int W = wpt_pkg::NUMBER_WIDTH;

  wpt_pkg::state_t state;

  wpt_pkg::num_t n;       // number under test
  wpt_pkg::num_t d;       // current trial divisor
  wpt_pkg::num_t rem;     // partial remainder of the divider
  wpt_pkg::num_t quot;    // dividend bits going out, quotient bits coming in
  logic [wpt_pkg::CNT_W-1:0]    cnt;
  logic [wpt_pkg::CACHE_AW-1:0] clr_addr;
  logic                         prime;
  logic                         out_valid;
  logic                         out_bit;

  // Map of primes found so far; cleared by the sweep after reset.
  logic prime_known_map [wpt_pkg::CACHE_DEPTH];
  logic map_q;

  wpt_pkg::num_t num_in;
  logic          out_free;
  logic          in_cache;
  logic          map_we;
  logic [wpt_pkg::CACHE_AW-1:0] map_waddr;
  logic          map_wdata;

  // One step of the restoring divider.
  logic [W:0]    rem_shift;
  logic [W:0]    rem_diff;
  logic          take;
  wpt_pkg::num_t rem_step;
  wpt_pkg::num_t quot_step;

  assign num_in   = request.number[W-1:0];
  assign out_free = !out_valid || result.ready;
  assign in_cache = (32'(n) < 32'(wpt_pkg::CACHE_DEPTH));

  assign request.ready   = (state == wpt_pkg::ST_IDLE);
  assign result.valid    = out_valid;
  assign result.is_prime = out_bit;

  assign rem_shift = {rem, quot[W-1]};
  assign rem_diff  = rem_shift - {1'b0, d};
  assign take      = !rem_diff[W];
  assign rem_step  = take ? rem_diff[W-1:0] : rem_shift[W-1:0];
  assign quot_step = {quot[W-2:0], take};

  // The map is written by the clearing sweep and whenever a prime below the depth is finished.
  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_addr;
    map_wdata = 1'b0;
    if (state == wpt_pkg::ST_CLEAR) begin
      map_we = 1'b1;
    end else if (state == wpt_pkg::ST_FINISH && out_free && prime && in_cache) begin
      map_we    = 1'b1;
      map_waddr = wpt_pkg::CACHE_AW'(n);
      map_wdata = 1'b1;
    end
  end

  // The read address follows the request field, so the entry of an accepted number is
  // ready in the cycle after acceptance.
  always_ff @(posedge clk) begin
    if (map_we) begin
      prime_known_map[map_waddr] <= map_wdata;
    end
    map_q <= prime_known_map[wpt_pkg::CACHE_AW'(num_in)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wpt_pkg::ST_CLEAR;
      clr_addr  <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // The output register fills when a finished answer moves in, and otherwise empties
      // once its result is taken.
      out_valid <= (state == wpt_pkg::ST_FINISH && out_free) || (out_valid && !result.ready);

      unique case (state)
        wpt_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + wpt_pkg::CACHE_AW'(1);
          if (clr_addr == wpt_pkg::CACHE_AW'(wpt_pkg::CACHE_DEPTH - 1)) begin
            state <= wpt_pkg::ST_IDLE;
          end
        end

        wpt_pkg::ST_IDLE: begin
          if (request.valid) begin
            n     <= num_in;
            state <= wpt_pkg::ST_LOOKUP;
          end
        end

        wpt_pkg::ST_LOOKUP: begin
          // Quick answers first; otherwise start dividing by three.
          if (in_cache && map_q) begin
            prime <= 1'b1;
            state <= wpt_pkg::ST_FINISH;
          end else if (n < W'(2)) begin
            prime <= 1'b0;
            state <= wpt_pkg::ST_FINISH;
          end else if (n < W'(4)) begin
            prime <= 1'b1;
            state <= wpt_pkg::ST_FINISH;
          end else if (!n[0]) begin
            prime <= 1'b0;
            state <= wpt_pkg::ST_FINISH;
          end else begin
            d     <= W'(3);
            rem   <= '0;
            quot  <= n;
            cnt   <= '0;
            state <= wpt_pkg::ST_DIVIDE;
          end
        end

        wpt_pkg::ST_DIVIDE: begin
          rem  <= rem_step;
          quot <= quot_step;
          cnt  <= cnt + wpt_pkg::CNT_W'(1);
          if (cnt == wpt_pkg::CNT_W'(W - 1)) begin
            state <= wpt_pkg::ST_CHECK;
          end
        end

        wpt_pkg::ST_CHECK: begin
          // A quotient below the divisor means d*d > n: no factor is left to find.
          if (quot < d) begin
            prime <= 1'b1;
            state <= wpt_pkg::ST_FINISH;
          end else if (rem == '0) begin
            prime <= 1'b0;
            state <= wpt_pkg::ST_FINISH;
          end else begin
            d     <= d + W'(2);
            rem   <= '0;
            quot  <= n;
            cnt   <= '0;
            state <= wpt_pkg::ST_DIVIDE;
          end
        end

        wpt_pkg::ST_FINISH: begin
          if (out_free) begin
            out_bit <= prime;
            state   <= wpt_pkg::ST_IDLE;
          end
        end

        default: begin
          state <= wpt_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

[design/wpt_checker.sv]
// Port-level checker for the Wilson primality tester, with its bind to the top level.
// Depends on wpt_pkg and on the ports of wilson_primality_test.
module wpt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [wpt_pkg::PORT_W-1:0] number,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       is_prime
);

  // A pending result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(is_prime))
    else $error("result changed while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // A result only appears as the end of a request in work.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request in work");

  // Zero is not reported prime at once: an accepted zero is not followed straight away
  // by a newly valid result that reports prime.
  a_zero_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (number[wpt_pkg::NUMBER_WIDTH-1:0] == '0) |=> !out_valid || !is_prime
      || $past(out_valid))
    else $error("zero reported prime");

endmodule

bind wilson_primality_test wpt_checker u_wpt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (request.valid),
  .in_ready  (request.ready),
  .number    (request.number),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .is_prime  (result.is_prime)
);

[tb/sv/tb_wilson_primality_test.sv]
// Self-checking testbench for the Wilson primality tester (wilson_primality_test).
// Depends on wpt_pkg and on the channel interfaces wpt_in_if and wpt_out_if.
// Drives directed and random requests and checks every answer against a trial-division predictor.
module tb_wilson_primality_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One answer the block owes us, together with the request that caused it.
  typedef struct {
    logic [wpt_pkg::PORT_W-1:0] number;
    bit                         is_prime;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wpt_in_if  req_ch ();
  wpt_out_if res_ch ();

  wilson_primality_test dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch)
  );

  // Answers still owed by the block, oldest first.
  answer_t expected_answers[$];
  // Our own copy of the map of primes found below the cache depth.
  bit      known_prime [wpt_pkg::CACHE_DEPTH];
  int      error_count    = 0;
  // Chance, in percent, that the sender idles or the receiver stalls in a cycle.
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;

  // Working variables of the answer checker.
  answer_t owed;

  // 4 ns clock: two ns high, two ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The whole run must fit well inside this time. The limit leaves a wide margin and
  // still stops a hang.
  initial begin
    #20_000_000;
    $display("[wilson_primality_test] ERROR");
    $finish;
  end

  // Smallest factor of n that is at least 2. A prime returns itself, and zero and one
  // return zero since they have no such factor.
  function automatic longint unsigned least_factor(input longint unsigned n);
    longint unsigned d;
    if (n < 2) return 0;
    if (n[0] == 1'b0) return 2;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return d;
    end
    return n;
  endfunction

  // Works out the block's answer for one request and updates the prime map the same way
  // the block does. The map can only confirm a prime, so it never changes an answer, but
  // keeping it lets us follow the block's state exactly.
  function automatic bit predict_prime(input logic [wpt_pkg::PORT_W-1:0] value);
    wpt_pkg::num_t n;
    bit            prime;
    n = value[wpt_pkg::NUMBER_WIDTH-1:0];
    if (n < wpt_pkg::CACHE_DEPTH && known_prime[n[wpt_pkg::CACHE_AW-1:0]]) return 1'b1;
    prime = (least_factor(longint'(n)) == longint'(n)) && (n >= 2);
    if (prime && n < wpt_pkg::CACHE_DEPTH) known_prime[n[wpt_pkg::CACHE_AW-1:0]] = 1'b1;
    return prime;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Offers one request, idling first at random, and holds it until the block takes it.
  // The expected answer is worked out at the very edge where the request is accepted.
  task automatic send_number(input logic [wpt_pkg::PORT_W-1:0] value);
    answer_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid  <= 1'b1;
    req_ch.number <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    entry.number   = value;
    entry.is_prime = predict_prime(value);
    expected_answers.push_back(entry);
  endtask

  // Takes the request line down and waits until every owed answer has come back.
  task automatic wait_for_answers();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  // Random candidates. Large values are limited to those with a small factor, since a
  // large prime would need a division for every odd divisor up to its square root. Half
  // of the values stay below twice the cache depth, so the map is filled and hit often.
  function automatic logic [wpt_pkg::PORT_W-1:0] pick_number();
    logic [wpt_pkg::PORT_W-1:0] value;
    int                         pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      value = $urandom_range(2 * wpt_pkg::CACHE_DEPTH - 1);
    end else if (pick < 75) begin
      value = $urandom_range(65535);
    end else begin
      do value = $urandom; while (least_factor(longint'(value)) > 601);
    end
    return value;
  endfunction

  // Receiver: stalls at random, as the current phase asks. Ready changes only at the
  // falling edge.
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Answer checker: every answer taken is compared with the oldest one still owed.
  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_answers.size() == 0) begin
        report_mismatch($sformatf("answer %b arrived with no request pending", res_ch.is_prime));
      end else begin
        owed = expected_answers.pop_front();
        if (res_ch.is_prime !== owed.is_prime)
          report_mismatch($sformatf("number %0d: is_prime %b, should be %b",
                                    owed.number, res_ch.is_prime, owed.is_prime));
      end
    end
  end

  // Zero and one are not prime, two and three are the smallest primes, a small even value
  // takes the quick path and small odd values cover the first steps of the divider.
  task automatic test_trivial_values();
    send_number(0);
    send_number(1);
    send_number(2);
    send_number(3);
    send_number(4);
    send_number(5);
    send_number(9);
  endtask

  // Primes just below the cache depth are stored and then answered from the map; values
  // at and above the depth are worked out every time. The square of the largest cached
  // prime needs many trial divisors before it is found composite.
  task automatic test_prime_map();
    send_number(1021);
    send_number(1021);
    send_number(2);
    send_number(wpt_pkg::CACHE_DEPTH - 1);
    send_number(wpt_pkg::CACHE_DEPTH);
    send_number(1031);
    send_number(1031);
    send_number(1021 * 1021);
  endtask

  // Values that use the full width of the field. Only primes of moderate size are sent, since
  // a prime near the top of the range would need a division for every odd divisor up to its root.
  task automatic test_wide_values();
    send_number(65521);
    send_number(1048573);
    send_number(16777213);
    send_number(32'hFFFF_FFFF);
    send_number(32'hFFFF_FFFE);
    send_number(32'h8000_0000);
    send_number(32'h5555_5555);
    send_number(32'hAAAA_AAAB);
  endtask

  // A stretch of random requests under one setting of sender idling and receiver stalls.
  // Each phase ends by draining, so the sender at least once waits for every answer.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_number(pick_number());
    wait_for_answers();
  endtask

  initial begin
    req_ch.valid  = 1'b0;
    req_ch.number = '0;
    foreach (known_prime[i]) known_prime[i] = 1'b0;

    // Reset is held and then released at a falling edge. The block then clears its map before
    // it takes the first request, which the sender simply waits out through the handshake.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_trivial_values();
    test_prime_map();
    test_wide_values();
    wait_for_answers();

    test_random_traffic(0, 0, 20);
    test_random_traffic(78, 0, 20);
    test_random_traffic(0, 78, 20);
    test_random_traffic(33, 33, 20);

    // Give a stray extra answer time to show up before deciding.
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);
    if (expected_answers.size() != 0)
      report_mismatch($sformatf("%0d answers never arrived", expected_answers.size()));

    if (error_count == 0) begin
      $display("[wilson_primality_test] OK");
    end else begin
      $display("[wilson_primality_test] ERROR");
    end
    $finish;
  end

endmodule

[wilson_primality_test.f]
design/wpt_pkg.sv
design/wpt_if.sv
design/wilson_primality_test.sv
design/wpt_checker.sv
tb/sv/tb_wilson_primality_test.sv
